FILE: src/ggew_pkg.sv
// Shared constants, register indexes and helper functions for the grid graph edge block.
`timescale 1ns / 1ps
`default_nettype none

package ggew_pkg;

   // Frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field and counter widths
   localparam int PIXEL_W  = 8;
   localparam int VERTEX_W = 20;
   localparam int SIZE_W   = 11;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(1024);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] result;
      if (value < MIN_SIZE) begin
         result = MIN_SIZE;
      end else if (value > hi) begin
         result = hi;
      end else begin
         result = value;
      end
      return result;
   endfunction

   function automatic logic [PIXEL_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
      logic [PIXEL_W-1:0] result;
      if (a > b) begin
         result = a - b;
      end else begin
         result = b - a;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: src/ggew_ram.sv
// Generic single-port-write, single-port-read RAM with registered, read-first output.
`timescale 1ns / 1ps
`default_nettype none

module ggew_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: src/grid_graph_edge_weights.sv
// Top level: turns a raster pixel stream into weighted 4-neighbour grid graph edges.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req_* carries one 8-bit gray pixel per word, in raster order. rsp_* carries one
//   edge per word: the edge from the left neighbour first, then the edge from the
//   pixel above, with rsp_last_of_item marking the final edge of a pixel. The first
//   pixel of a frame makes no edge. csr_* sets image width and height (2..1024)
//   between frames; out-of-range values saturate.
//   The first edge of a pixel passes through the edge stage, then the output register.
//   Throughput: while rsp_stall is low, one pixel per cycle on the first row and in
//   column zero; elsewhere the next pixel is stalled until the edge from above is sent.
//   The previous row lives in a 1024 x 8 RAM read and written once per pixel.
//   A pixel is taken while the prior edge still waits in the output register.
//   Reset clears counters, pending work and rsp_valid and restores 1024 x 1024;
//   the line RAM needs no clearing. While rsp_stall is high the edge word holds
//   and, once the edge stage is full, req_stall rises.

module grid_graph_edge_weights (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Pixel input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ggew_pkg::PIXEL_W-1:0]          req_pixel_value,
   // Edge output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [ggew_pkg::VERTEX_W-1:0]         rsp_vertex_from,
   output logic      [ggew_pkg::VERTEX_W-1:0]         rsp_vertex_to,
   output logic      [ggew_pkg::PIXEL_W-1:0]          rsp_edge_weight,
   output logic                                       rsp_from_above,
   output logic                                       rsp_last_of_item,
   // Configuration
   input  wire logic                                  csr_write_enable,
   input  wire logic [ggew_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ggew_pkg::SIZE_W-1:0]           csr_write_data
);

   // Configuration registers
   logic [ggew_pkg::SIZE_W-1:0] image_width_ff, image_width_in;
   logic [ggew_pkg::SIZE_W-1:0] image_height_ff, image_height_in;
   logic [ggew_pkg::SIZE_W-1:0] width_eff, height_eff;

   // Raster position
   logic [ggew_pkg::COL_W-1:0]    column_count_ff, column_count_in;
   logic [ggew_pkg::ROW_W-1:0]    row_count_ff, row_count_in;
   logic [ggew_pkg::VERTEX_W-1:0] vertex_count_ff, vertex_count_in;
   logic [ggew_pkg::PIXEL_W-1:0]  left_pixel_ff, left_pixel_in;

   // Edge stage: one pixel waiting to emit its edges
   logic                          a_valid_ff, a_valid_in;
   logic                          a_need_left_ff, a_need_left_in;
   logic                          a_need_up_ff, a_need_up_in;
   logic [ggew_pkg::PIXEL_W-1:0]  a_pixel_ff, a_pixel_in;
   logic [ggew_pkg::PIXEL_W-1:0]  a_left_ff, a_left_in;
   logic [ggew_pkg::VERTEX_W-1:0] a_cur_ff, a_cur_in;
   logic [ggew_pkg::VERTEX_W-1:0] a_up_from_ff, a_up_from_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ggew_pkg::VERTEX_W-1:0] rsp_from_ff, rsp_from_in;
   logic [ggew_pkg::VERTEX_W-1:0] rsp_to_ff, rsp_to_in;
   logic [ggew_pkg::PIXEL_W-1:0]  rsp_weight_ff, rsp_weight_in;
   logic                          rsp_above_ff, rsp_above_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          accept;
   logic                          out_load;
   logic                          emit;
   logic                          edge_last;
   logic                          a_free;
   logic                          row_end;
   logic                          frame_end;
   logic [ggew_pkg::PIXEL_W-1:0]  above_pixel;

   assign width_eff  = ggew_pkg::clamp_size(image_width_ff, ggew_pkg::MAX_WIDTH_SZ);
   assign height_eff = ggew_pkg::clamp_size(image_height_ff, ggew_pkg::MAX_HEIGHT_SZ);

   // Configuration writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ggew_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            ggew_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_write_data;
            default:                    image_width_in  = image_width_ff;
         endcase
      end
   end

   // Handshake
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = a_valid_ff && out_load;
   assign edge_last = !a_need_left_ff || !a_need_up_ff;
   assign a_free    = emit && edge_last;
   assign req_stall = a_valid_ff && !a_free;
   assign accept    = req_valid && !req_stall;

   // Line RAM: read the previous row's pixel and overwrite it in the same cycle
   ggew_ram #(
      .WIDTH (ggew_pkg::PIXEL_W),
      .DEPTH (ggew_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock        (clock),
      .write_enable (accept),
      .write_addr   (column_count_ff),
      .write_data   (req_pixel_value),
      .read_enable  (accept),
      .read_addr    (column_count_ff),
      .read_data    (above_pixel)
   );

   assign row_end   = ggew_pkg::SIZE_W'(column_count_ff) >= (width_eff - ggew_pkg::SIZE_W'(1));
   assign frame_end = ggew_pkg::SIZE_W'(row_count_ff) >= (height_eff - ggew_pkg::SIZE_W'(1));

   // Advance the raster position on every taken pixel
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      vertex_count_in = vertex_count_ff;
      left_pixel_in   = left_pixel_ff;
      if (accept) begin
         left_pixel_in   = req_pixel_value;
         vertex_count_in = vertex_count_ff + ggew_pkg::VERTEX_W'(1);
         if (row_end) begin
            column_count_in = '0;
            if (frame_end) begin
               row_count_in    = '0;
               vertex_count_in = '0;
               left_pixel_in   = '0;
            end else begin
               row_count_in = row_count_ff + ggew_pkg::ROW_W'(1);
            end
         end else begin
            column_count_in = column_count_ff + ggew_pkg::COL_W'(1);
         end
      end
   end

   // Edge stage load and drain
   always_comb begin
      a_valid_in     = a_valid_ff;
      a_need_left_in = a_need_left_ff;
      a_need_up_in   = a_need_up_ff;
      a_pixel_in     = a_pixel_ff;
      a_left_in      = a_left_ff;
      a_cur_in       = a_cur_ff;
      a_up_from_in   = a_up_from_ff;
      if (emit) begin
         // The left edge goes first; drop it once sent
         a_need_left_in = 1'b0;
         if (edge_last) begin
            a_valid_in = 1'b0;
         end
      end
      if (accept) begin
         a_need_left_in = column_count_ff != '0;
         a_need_up_in   = row_count_ff != '0;
         a_valid_in     = (column_count_ff != '0) || (row_count_ff != '0);
         a_pixel_in     = req_pixel_value;
         a_left_in      = left_pixel_ff;
         a_cur_in       = vertex_count_ff;
         a_up_from_in   = vertex_count_ff - ggew_pkg::VERTEX_W'(width_eff);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_above_in  = rsp_above_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_to_in   = a_cur_ff;
            rsp_last_in = edge_last;
            if (a_need_left_ff) begin
               rsp_from_in   = a_cur_ff - ggew_pkg::VERTEX_W'(1);
               rsp_weight_in = ggew_pkg::abs_diff(a_pixel_ff, a_left_ff);
               rsp_above_in  = 1'b0;
            end else begin
               rsp_from_in   = a_up_from_ff;
               rsp_weight_in = ggew_pkg::abs_diff(a_pixel_ff, above_pixel);
               rsp_above_in  = 1'b1;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= ggew_pkg::WIDTH_RESET;
         image_height_ff <= ggew_pkg::HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         vertex_count_ff <= '0;
         left_pixel_ff   <= '0;
         a_valid_ff      <= 1'b0;
         a_need_left_ff  <= 1'b0;
         a_need_up_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         vertex_count_ff <= vertex_count_in;
         left_pixel_ff   <= left_pixel_in;
         a_valid_ff      <= a_valid_in;
         a_need_left_ff  <= a_need_left_in;
         a_need_up_ff    <= a_need_up_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      a_pixel_ff    <= a_pixel_in;
      a_left_ff     <= a_left_in;
      a_cur_ff      <= a_cur_in;
      a_up_from_ff  <= a_up_from_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_above_ff  <= rsp_above_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_from  = rsp_from_ff;
   assign rsp_vertex_to    = rsp_to_ff;
   assign rsp_edge_weight  = rsp_weight_ff;
   assign rsp_from_above   = rsp_above_ff;
   assign rsp_last_of_item = rsp_last_ff;

endmodule

`default_nettype wire

FILE: src/ggew_checker.sv
// Port-level checks on the edge output of the grid graph edge block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ggew_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [ggew_pkg::VERTEX_W-1:0]     rsp_vertex_from,
   input wire logic [ggew_pkg::VERTEX_W-1:0]     rsp_vertex_to,
   input wire logic [ggew_pkg::PIXEL_W-1:0]      rsp_edge_weight,
   input wire logic                              rsp_from_above,
   input wire logic                              rsp_last_of_item
);

   // A stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex_from)
         && $stable(rsp_vertex_to) && $stable(rsp_edge_weight)
         && $stable(rsp_from_above) && $stable(rsp_last_of_item))
      else $error("edge word changed while stalled");

   // A horizontal edge joins consecutive vertices
   a_horiz_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_above |-> rsp_vertex_from == rsp_vertex_to - 20'd1)
      else $error("horizontal edge endpoints not adjacent");

   // The vertical edge is always the last of its pixel
   a_vert_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_above |-> rsp_last_of_item)
      else $error("vertical edge not marked last");

   // No edge right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("edge shown right after reset");

endmodule

bind grid_graph_edge_weights ggew_checker u_ggew_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_vertex_from  (rsp_vertex_from),
   .rsp_vertex_to    (rsp_vertex_to),
   .rsp_edge_weight  (rsp_edge_weight),
   .rsp_from_above   (rsp_from_above),
   .rsp_last_of_item (rsp_last_of_item)
);

`default_nettype wire
